### sv/iepm_pkg.sv
// Shared types, codes and bus level tables for the I2C port expander master.
package iepm_pkg;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_DEVICE_ADDRESS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_TICKS = 2'd1;

  localparam logic [6:0] DEVICE_ADDRESS_RST = 7'd32;
  localparam logic [7:0] PHASE_TICKS_RST = 8'd1;

  localparam logic [1:0] KIND_TICK = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_READ = 2'd2;

  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

  typedef enum logic [16:0] {
    PH_IDLE_HI = 17'h00001,
    PH_IDLE_LO = 17'h00002,
    PH_ST_A    = 17'h00004,
    PH_ST_B    = 17'h00008,
    PH_TB_SET  = 17'h00010,
    PH_TB_HIGH = 17'h00020,
    PH_TA_SET  = 17'h00040,
    PH_TA_HIGH = 17'h00080,
    PH_TA_LOW  = 17'h00100,
    PH_RB_HIGH = 17'h00200,
    PH_RB_LOW  = 17'h00400,
    PH_NK_SET  = 17'h00800,
    PH_NK_HIGH = 17'h01000,
    PH_NK_LOW  = 17'h02000,
    PH_SP_A    = 17'h04000,
    PH_SP_B    = 17'h08000,
    PH_SP_C    = 17'h10000
  } phase_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] write_data;
    logic       sda_in;
  } in_item_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic       failed;
    logic [7:0] read_data;
  } out_item_t;

  function automatic logic scl_level(input phase_t ph);
    logic lvl;
    case (ph)
      PH_IDLE_LO, PH_TB_SET, PH_TA_SET, PH_TA_LOW, PH_RB_LOW,
      PH_NK_SET, PH_NK_LOW, PH_SP_A: lvl = 1'b0;
      default: lvl = 1'b1;
    endcase
    return lvl;
  endfunction

  function automatic logic sda_level(input phase_t ph);
    logic lvl;
    case (ph)
      PH_ST_B, PH_SP_A, PH_SP_B: lvl = 1'b0;
      default: lvl = 1'b1;
    endcase
    return lvl;
  endfunction

endpackage

### sv/iepm_seq.sv
// Bus sequencer: transaction state and the per-item step that yields one result.
module iepm_seq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  iepm_pkg::in_item_t  item,
  input  logic [6:0]          device_address,
  input  logic [7:0]          phase_ticks,
  output iepm_pkg::out_item_t result
);
  import iepm_pkg::*;

  phase_t     phase_r, phase_nxt;
  logic [3:0] bit_cnt_r, bit_cnt_nxt;
  logic [7:0] shift_r, shift_nxt;
  logic [7:0] wait_r, wait_nxt;
  logic       is_read_r, is_read_nxt;
  logic       fail_r, fail_nxt;
  logic [7:0] rx_byte_r, rx_byte_nxt;
  logic [7:0] tx_byte_r, tx_byte_nxt;
  logic       data_stage_r, data_stage_nxt;

  logic       busy;
  logic       busy_nxt;
  logic       done;
  logic [7:0] ticks_eff;
  logic [3:0] cnt_inc;

  assign busy = (phase_r != PH_IDLE_HI) && (phase_r != PH_IDLE_LO);
  assign busy_nxt = (phase_nxt != PH_IDLE_HI) && (phase_nxt != PH_IDLE_LO);
  // A zero phase length behaves as one tick.
  assign ticks_eff = (phase_ticks == 8'd0) ? 8'd1 : phase_ticks;
  assign cnt_inc = bit_cnt_r + 4'd1;

  always_comb begin
    phase_nxt = phase_r;
    bit_cnt_nxt = bit_cnt_r;
    shift_nxt = shift_r;
    wait_nxt = wait_r;
    is_read_nxt = is_read_r;
    fail_nxt = fail_r;
    rx_byte_nxt = rx_byte_r;
    tx_byte_nxt = tx_byte_r;
    data_stage_nxt = data_stage_r;
    done = 1'b0;

    if (step) begin
      if (item.kind == KIND_TICK) begin
        if (busy) begin
          if (wait_r > 8'd1) begin
            wait_nxt = wait_r - 8'd1;
          end else begin
            // The phase ends: most arms enter a new phase with a full wait.
            wait_nxt = ticks_eff;
            case (phase_r)
              PH_ST_A: phase_nxt = PH_ST_B;
              PH_ST_B: begin
                bit_cnt_nxt = 4'd0;
                phase_nxt = PH_TB_SET;
              end
              PH_TB_SET: phase_nxt = PH_TB_HIGH;
              PH_TB_HIGH: begin
                shift_nxt = {shift_r[6:0], 1'b0};
                bit_cnt_nxt = cnt_inc;
                phase_nxt = (cnt_inc < BITS_PER_BYTE) ? PH_TB_SET : PH_TA_SET;
              end
              PH_TA_SET: phase_nxt = PH_TA_HIGH;
              PH_TA_HIGH: begin
                if (item.sda_in) begin
                  fail_nxt = 1'b1;
                  if (data_stage_r) begin
                    // Data NACK leaves the clock low and ends at once.
                    phase_nxt = PH_IDLE_LO;
                    wait_nxt = 8'd0;
                    done = 1'b1;
                  end else begin
                    phase_nxt = PH_SP_A;
                  end
                end else begin
                  phase_nxt = PH_TA_LOW;
                end
              end
              PH_TA_LOW: begin
                if (data_stage_r) begin
                  phase_nxt = PH_SP_A;
                end else if (is_read_r) begin
                  bit_cnt_nxt = 4'd0;
                  shift_nxt = 8'd0;
                  phase_nxt = PH_RB_HIGH;
                end else begin
                  data_stage_nxt = 1'b1;
                  shift_nxt = tx_byte_r;
                  bit_cnt_nxt = 4'd0;
                  phase_nxt = PH_TB_SET;
                end
              end
              PH_RB_HIGH: begin
                shift_nxt = {shift_r[6:0], item.sda_in};
                phase_nxt = PH_RB_LOW;
              end
              PH_RB_LOW: begin
                bit_cnt_nxt = cnt_inc;
                phase_nxt = (cnt_inc < BITS_PER_BYTE) ? PH_RB_HIGH : PH_NK_SET;
              end
              PH_NK_SET: phase_nxt = PH_NK_HIGH;
              PH_NK_HIGH: phase_nxt = PH_NK_LOW;
              PH_NK_LOW: phase_nxt = PH_SP_A;
              PH_SP_A: phase_nxt = PH_SP_B;
              PH_SP_B: phase_nxt = PH_SP_C;
              PH_SP_C: begin
                if (is_read_r && !fail_r) begin
                  rx_byte_nxt = shift_r;
                end
                phase_nxt = PH_IDLE_HI;
                wait_nxt = 8'd0;
                done = 1'b1;
              end
              default: begin
                phase_nxt = PH_IDLE_HI;
                wait_nxt = 8'd0;
              end
            endcase
          end
        end
      end else if ((item.kind inside {KIND_WRITE, KIND_READ}) && !busy) begin
        is_read_nxt = (item.kind == KIND_READ);
        tx_byte_nxt = item.write_data;
        data_stage_nxt = 1'b0;
        fail_nxt = 1'b0;
        bit_cnt_nxt = 4'd0;
        shift_nxt = {device_address, (item.kind == KIND_READ)};
        phase_nxt = PH_ST_A;
        wait_nxt = ticks_eff;
      end
    end
  end

  always_comb begin
    result.scl_out = scl_level(phase_nxt);
    if ((phase_nxt == PH_TB_SET) || (phase_nxt == PH_TB_HIGH)) begin
      result.sda_out = shift_nxt[7];
    end else begin
      result.sda_out = sda_level(phase_nxt);
    end
    result.busy_res = busy_nxt;
    result.done_res = done;
    result.failed = fail_nxt;
    result.read_data = rx_byte_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE_HI;
      bit_cnt_r <= 4'd0;
      shift_r <= 8'd0;
      wait_r <= 8'd0;
      is_read_r <= 1'b0;
      fail_r <= 1'b0;
      rx_byte_r <= 8'd0;
      data_stage_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      bit_cnt_r <= bit_cnt_nxt;
      shift_r <= shift_nxt;
      wait_r <= wait_nxt;
      is_read_r <= is_read_nxt;
      fail_r <= fail_nxt;
      rx_byte_r <= rx_byte_nxt;
      data_stage_r <= data_stage_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tx_byte_r <= tx_byte_nxt;
  end

endmodule

### sv/i2c_expander_port_master_unit.sv
// Top level: I2C port expander master with config registers and result register.
// Latency: the result of an item is registered on the edge that accepts it and
// is offered on out_valid from the next cycle.
// Throughput: one item per cycle while out_ready holds; the sequencer steps once per accepted item.
// Reset (rst_n low, synchronous): bus released and idle, no result pending,
// device_address back to 32 and phase_ticks back to 1.
module i2c_expander_port_master_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  iepm_pkg::in_item_t                 in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output iepm_pkg::out_item_t                out_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [iepm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [iepm_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import iepm_pkg::*;

  logic [6:0] dev_addr_r;
  logic [7:0] ticks_r;
  logic       out_valid_r;
  out_item_t  out_data_r;
  out_item_t  step_result;
  logic       in_accept;

  assign cfg_ready = 1'b1;
  assign in_ready = out_ready || !out_valid_r;
  assign in_accept = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data = out_data_r;

  iepm_seq u_seq (
    .clk            (clk),
    .rst_n          (rst_n),
    .step           (in_accept),
    .item           (in_data),
    .device_address (dev_addr_r),
    .phase_ticks    (ticks_r),
    .result         (step_result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_addr_r <= DEVICE_ADDRESS_RST;
      ticks_r <= PHASE_TICKS_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_DEVICE_ADDRESS: dev_addr_r <= cfg_wdata[6:0];
        REG_PHASE_TICKS: ticks_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_data_r <= step_result;
    end
  end

endmodule

### sv/iepm_checker.sv
// Port-level checks for the I2C port expander master, bound to the top level.
module iepm_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input iepm_pkg::out_item_t out_data
);
  import iepm_pkg::*;

  // A stalled result holds until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result pending after reset");

  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.done_res && out_data.busy_res))
    else $error("finished item still reports busy");

  // A transaction that ends without a missing acknowledge leaves the bus released.
  a_clean_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.done_res && !out_data.failed |->
      out_data.scl_out && out_data.sda_out)
    else $error("successful transaction did not release the bus");

  a_idle_sda: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.busy_res |-> out_data.sda_out)
    else $error("data line driven low while idle");

endmodule

bind i2c_expander_port_master_unit iepm_checker u_iepm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
